>>> src/fsndm_pkg.sv
package fsndm_pkg;

    localparam int NAME_CHARS  = 12;
    localparam int BASE_CHARS  = 8;
    localparam int EXT_CHARS   = 3;
    localparam int RAW_CHARS   = BASE_CHARS + EXT_CHARS;

    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;

    localparam logic [7:0] CHAR_FREE      = 8'h00;
    localparam logic [7:0] CHAR_DELETED   = 8'hE5;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam int         ATTR_DIR_BIT   = 4;

    // Register select is address bit 3: register 0 at 0x0, register 1 at 0x8.
    localparam logic REG_SEARCH_LOW  = 1'b0;
    localparam logic REG_SEARCH_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_SKIPPED  = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_MATCH    = 2'd2,
        ST_PAST_END = 2'd3
    } t_status;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

>>> src/fat_short_name_dir_matcher_core.sv
// FAT 8.3 short-name matcher. Each slave request carries one directory entry's
// fields and yields exactly one master request with a status (skipped, no match,
// match, past end) and, on a match, the first cluster, directory flag and file
// size. The sought name (up to 12 characters, zero terminated, compared
// upper-cased) is written over the APB port: characters 0..7 at 0x0, 8..11 at
// 0x8. An entry whose first byte is zero ends the directory; every later entry
// reports past end until a request with tuser set starts a new scan. From slave
// acceptance to master valid an entry passes one input register and one result
// register, with the whole name build and 12-character compare between them.
// One entry is accepted every cycle while the master side keeps up.
module fat_short_name_dir_matcher_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata: base_name[63:0], extension[87:64], attributes[95:88],
    // cluster_high[111:96], cluster_low[127:112], length_bytes[159:128]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fsndm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // s_axis_tuser: start_of_search[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // m_axis_tdata: start_cluster[31:0], is_directory[32], file_length[64:33],
    // zero fill[71:65]
    output logic [fsndm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // m_axis_tuser: status[1:0]
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fsndm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fsndm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fsndm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import fsndm_pkg::*;

    logic [63:0]                r_search_low;
    logic [31:0]                r_search_high;
    logic                       r_ended;
    logic                       n_ended;

    logic                       r_in_valid;
    logic                       r_in_start;
    logic [IN_DATA_W-1:0]       r_in_data;

    logic                       r_out_valid;
    t_status                    r_out_status;
    logic [31:0]                r_out_cluster;
    logic                       r_out_dir;
    logic [31:0]                r_out_length;

    t_status                    n_status;
    logic                       advance;

    logic [7:0]                 raw      [RAW_CHARS];
    logic [7:0]                 sought   [NAME_CHARS];
    logic [7:0]                 built    [NAME_CHARS];
    logic [NAME_CHARS-1:0]      alive_s;
    logic [NAME_CHARS-1:0]      alive_b;
    logic [3:0]                 base_len;
    logic [1:0]                 ext_len;
    logic                       has_ext;
    logic                       names_equal;
    logic                       ended_now;
    logic [7:0]                 attr;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_SEARCH_HIGH) ? {32'd0, r_search_high} : r_search_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_low  <= '0;
            r_search_high <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_SEARCH_HIGH) begin
                r_search_high <= pwdata[31:0];
            end else begin
                r_search_low <= pwdata;
            end
        end
    end

    // Pipeline handshake: the input stage moves on whenever the result
    // register is empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_start <= s_axis_tuser;
            r_in_data  <= s_axis_tdata;
        end
    end

    // Name build and compare
    always_comb begin
        int j;
        logic stop;
        for (int k = 0; k < BASE_CHARS; k++) begin
            raw[k] = r_in_data[8*k +: 8];
        end
        for (int k = 0; k < EXT_CHARS; k++) begin
            raw[BASE_CHARS+k] = r_in_data[64 + 8*k +: 8];
        end
        attr = r_in_data[95:88];

        base_len = 4'(BASE_CHARS);
        stop     = 1'b0;
        for (int k = 0; k < BASE_CHARS; k++) begin
            if (!stop && raw[k] == CHAR_SPACE) begin
                base_len = 4'(k);
                stop     = 1'b1;
            end
        end
        ext_len = 2'(EXT_CHARS);
        stop    = 1'b0;
        for (int k = 0; k < EXT_CHARS; k++) begin
            if (!stop && raw[BASE_CHARS+k] == CHAR_SPACE) begin
                ext_len = 2'(k);
                stop    = 1'b1;
            end
        end
        has_ext = (raw[BASE_CHARS] != CHAR_SPACE);

        for (int k = 0; k < NAME_CHARS; k++) begin
            j = k - int'(base_len) - 1;
            if (k < BASE_CHARS && k < int'(base_len)) begin
                built[k] = upcase(raw[k]);
            end else if (has_ext && k == int'(base_len)) begin
                built[k] = CHAR_DOT;
            end else if (has_ext && j >= 0 && j < int'(ext_len)) begin
                built[k] = upcase(raw[BASE_CHARS + j]);
            end else begin
                built[k] = 8'h00;
            end
        end

        for (int k = 0; k < BASE_CHARS; k++) begin
            sought[k] = upcase(r_search_low[8*k +: 8]);
        end
        for (int k = 0; k < NAME_CHARS - BASE_CHARS; k++) begin
            sought[BASE_CHARS+k] = upcase(r_search_high[8*k +: 8]);
        end

        // A position is alive while no zero byte has appeared up to it.
        // Names are equal when they stop at the same place and agree before it.
        names_equal = 1'b1;
        for (int k = 0; k < NAME_CHARS; k++) begin
            alive_s[k] = (sought[k] != 8'h00) && (k == 0 || alive_s[k-1]);
            alive_b[k] = (built[k] != 8'h00) && (k == 0 || alive_b[k-1]);
            if (alive_s[k] != alive_b[k]) begin
                names_equal = 1'b0;
            end else if (alive_s[k] && sought[k] != built[k]) begin
                names_equal = 1'b0;
            end
        end

        ended_now = (r_ended && !r_in_start) || (raw[0] == CHAR_FREE);
        n_ended   = ended_now;

        if (ended_now) begin
            n_status = ST_PAST_END;
        end else if (raw[0] == CHAR_DELETED || attr == ATTR_LONG_NAME) begin
            n_status = ST_SKIPPED;
        end else if (names_equal) begin
            n_status = ST_MATCH;
        end else begin
            n_status = ST_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_ended <= n_ended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_status <= n_status;
            if (n_status == ST_MATCH) begin
                r_out_cluster <= {r_in_data[111:96], r_in_data[127:112]};
                r_out_dir     <= attr[ATTR_DIR_BIT];
                r_out_length  <= r_in_data[159:128];
            end else begin
                r_out_cluster <= '0;
                r_out_dir     <= 1'b0;
                r_out_length  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_length, r_out_dir, r_out_cluster};

endmodule

>>> src/fsndm_checker.sv
module fsndm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [fsndm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [1:0]                           m_axis_tuser
);
    import fsndm_pkg::*;

    // A stalled result request holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result request changed while stalled");

    // Only a match carries cluster, directory flag and length.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_MATCH |-> m_axis_tdata == '0)
        else $error("non-match result with nonzero payload");

    // The input side only backs up when the result side is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while result side is free");

    // A fresh result follows an accepted entry through the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && $past(i_rst_n) && $past(i_rst_n, 2) |->
            $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without an accepted entry");

endmodule

bind fat_short_name_dir_matcher_core fsndm_checker u_fsndm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
